[rtl/consistent_hash_ring_lookup_unit_macros.svh]
// Assertion macros for the checker file of the ring lookup unit.
`ifndef CONSISTENT_HASH_RING_LOOKUP_UNIT_MACROS_SVH
`define CONSISTENT_HASH_RING_LOOKUP_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CHRL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ring lookup assertion failed");

// Next-cycle implication, disabled while reset is high.
`define CHRL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ring lookup assertion failed");

`endif

[rtl/chrl_pkg.sv]
// ----------------------------------------------------------------------------
// chrl_pkg
// Types, codes and constants shared by the ring lookup unit's modules.
// ----------------------------------------------------------------------------
package chrl_pkg;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_LOOKUP = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [15:0] HASH_MUL  = 16'd40343;
  localparam logic [63:0] HASH_SEED = 64'd8;
  localparam logic [3:0]  HASH_STEPS = 4'd15;
  localparam logic [2:0]  HASH_LAST_PHASE = 3'd4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] node_id;
    logic [63:0] key;
  } in_t;

  typedef struct packed {
    logic [15:0] owner_node;
    logic [1:0]  status;
  } out_t;

  typedef struct packed {
    logic [63:0] pos;
    logic [15:0] owner;
  } entry_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_CLEAR,
    CMD_HSEED,
    CMD_HKEY,
    CMD_SRCH_INIT,
    CMD_SRCH_RD,
    CMD_SRCH_NEXT,
    CMD_OVERWRITE,
    CMD_SHIFT_INIT,
    CMD_SHIFT_RD,
    CMD_SHIFT_WR,
    CMD_INSERT,
    CMD_SET_FULL,
    CMD_NEXT_POINT,
    CMD_RM_INIT,
    CMD_RM_RD,
    CMD_RM_STEP,
    CMD_RM_DONE,
    CMD_LK_FIRST,
    CMD_LK_LAST,
    CMD_LK_WRAP,
    CMD_BS_INIT,
    CMD_BS_RD,
    CMD_BS_STEP,
    CMD_BS_DONE,
    CMD_FINISH
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       hash_done;
    logic       i_lt_count;
    logic       pos_lt_h;
    logic       pos_eq_h;
    logic       table_full;
    logic       k_gt_i;
    logic       rd_lt_count;
    logic       count_zero;
    logic       outside;
    logic       gap_gt1;
    logic       j_last;
  } dp_status_t;

endpackage

[rtl/chrl_ram.sv]
// ----------------------------------------------------------------------------
// chrl_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module chrl_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/chrl_datapath.sv]
// ----------------------------------------------------------------------------
// chrl_datapath
// Ring table, iterative triple hash, index registers and result register.
// ----------------------------------------------------------------------------
module chrl_datapath #(
  parameter int POINTS_PER_NODE = 16,
  parameter int RING_DEPTH      = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  chrl_pkg::dp_cmd_t   cmd,
  input  chrl_pkg::in_t       in_item,
  output chrl_pkg::dp_status_t stat,
  output chrl_pkg::out_t      out_item
);

  localparam int IW = $clog2(RING_DEPTH);
  localparam int CW = IW + 1;
  localparam int JW = (POINTS_PER_NODE > 1) ? $clog2(POINTS_PER_NODE) : 1;
  localparam int EW = $bits(chrl_pkg::entry_t);

  logic [1:0]  op;
  logic [15:0] node;
  logic [63:0] key;
  logic [CW-1:0] count;
  logic [CW-1:0] i, k, rd, wr;
  logic [IW-1:0] lo, hi;
  logic [15:0] lo_owner, owner_res;
  logic [63:0] pos0;
  logic        full_flag;
  logic [JW-1:0] j;

  // Hash unit: one multiply-accumulate per cycle, five per pass, three passes.
  logic [63:0] acc, hx, prod, chunk, seed;
  logic [3:0]  hcnt;
  logic [2:0]  hphase;

  logic               re, we;
  logic [IW-1:0]      raddr, waddr;
  chrl_pkg::entry_t   wdata, rent;
  logic [EW-1:0]      rdata;

  logic [CW-1:0] last, km1;
  logic [IW:0]   mid_sum, gap;
  logic [IW-1:0] mid;

  assign rent    = chrl_pkg::entry_t'(rdata);
  assign last    = count - CW'(1);
  assign km1     = k - CW'(1);
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[IW:1];
  assign gap     = {1'b0, hi} - {1'b0, lo};
  assign seed    = 64'(node) * 64'(POINTS_PER_NODE) + 64'(j);

  always_comb begin
    case (hphase)
      3'd0:    chunk = {48'd0, hx[15:0]};
      3'd1:    chunk = {48'd0, hx[31:16]};
      3'd2:    chunk = {48'd0, hx[47:32]};
      3'd3:    chunk = {48'd0, hx[63:48]};
      default: chunk = 64'd0;
    endcase
  end

  assign prod = acc * 64'(chrl_pkg::HASH_MUL) + chunk;

  assign stat.op          = op;
  assign stat.hash_done   = (hcnt == 4'd0);
  assign stat.i_lt_count  = (i < count);
  assign stat.pos_lt_h    = (rent.pos < hx);
  assign stat.pos_eq_h    = (rent.pos == hx);
  assign stat.table_full  = (count == CW'(RING_DEPTH));
  assign stat.k_gt_i      = (k > i);
  assign stat.rd_lt_count = (rd < count);
  assign stat.count_zero  = (count == CW'(0));
  assign stat.outside     = (hx < pos0) || (hx >= rent.pos);
  assign stat.gap_gt1     = (gap > (IW+1)'(1));
  assign stat.j_last      = (j == JW'(POINTS_PER_NODE - 1));

  always_comb begin
    re    = 1'b0;
    raddr = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = rent;
    unique case (cmd)
      chrl_pkg::CMD_SRCH_RD: begin
        re = 1'b1; raddr = i[IW-1:0];
      end
      chrl_pkg::CMD_SHIFT_RD: begin
        re = 1'b1; raddr = km1[IW-1:0];
      end
      chrl_pkg::CMD_RM_RD: begin
        re = 1'b1; raddr = rd[IW-1:0];
      end
      chrl_pkg::CMD_LK_FIRST: begin
        re = 1'b1; raddr = '0;
      end
      chrl_pkg::CMD_LK_LAST: begin
        re = 1'b1; raddr = last[IW-1:0];
      end
      chrl_pkg::CMD_BS_RD: begin
        re = 1'b1; raddr = mid;
      end
      chrl_pkg::CMD_OVERWRITE: begin
        we = 1'b1; waddr = i[IW-1:0]; wdata.pos = rent.pos; wdata.owner = node;
      end
      chrl_pkg::CMD_SHIFT_WR: begin
        we = 1'b1; waddr = k[IW-1:0];
      end
      chrl_pkg::CMD_INSERT: begin
        we = 1'b1; waddr = i[IW-1:0]; wdata.pos = hx; wdata.owner = node;
      end
      chrl_pkg::CMD_RM_STEP: begin
        we = (rent.owner != node); waddr = wr[IW-1:0];
      end
      default: begin
      end
    endcase
  end

  chrl_ram #(.WIDTH(EW), .DEPTH(RING_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (EW'(wdata)),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      hcnt  <= '0;
    end else begin
      if (hcnt != 4'd0) begin
        hcnt <= hcnt - 4'd1;
        if (hphase == chrl_pkg::HASH_LAST_PHASE) begin
          hx     <= prod;
          acc    <= chrl_pkg::HASH_SEED;
          hphase <= 3'd0;
        end else begin
          acc    <= prod;
          hphase <= hphase + 3'd1;
        end
      end
      unique case (cmd)
        chrl_pkg::CMD_LOAD: begin
          op        <= in_item.opcode;
          node      <= in_item.node_id;
          key       <= in_item.key;
          j         <= '0;
          owner_res <= '0;
          full_flag <= 1'b0;
        end
        chrl_pkg::CMD_CLEAR: count <= '0;
        chrl_pkg::CMD_HSEED, chrl_pkg::CMD_HKEY: begin
          hx     <= (cmd == chrl_pkg::CMD_HKEY) ? key : seed;
          acc    <= chrl_pkg::HASH_SEED;
          hphase <= 3'd0;
          hcnt   <= chrl_pkg::HASH_STEPS;
        end
        chrl_pkg::CMD_SRCH_INIT:  i <= '0;
        chrl_pkg::CMD_SRCH_NEXT:  i <= i + CW'(1);
        chrl_pkg::CMD_SHIFT_INIT: k <= count;
        chrl_pkg::CMD_SHIFT_WR:   k <= km1;
        chrl_pkg::CMD_INSERT:     count <= count + CW'(1);
        chrl_pkg::CMD_SET_FULL:   full_flag <= 1'b1;
        chrl_pkg::CMD_NEXT_POINT: j <= j + JW'(1);
        chrl_pkg::CMD_RM_INIT: begin
          rd <= '0;
          wr <= '0;
        end
        chrl_pkg::CMD_RM_STEP: begin
          rd <= rd + CW'(1);
          if (rent.owner != node) begin
            wr <= wr + CW'(1);
          end
        end
        chrl_pkg::CMD_RM_DONE: count <= wr;
        chrl_pkg::CMD_LK_LAST: begin
          pos0     <= rent.pos;
          lo_owner <= rent.owner;
        end
        chrl_pkg::CMD_LK_WRAP: owner_res <= rent.owner;
        chrl_pkg::CMD_BS_INIT: begin
          lo <= '0;
          hi <= last[IW-1:0];
        end
        chrl_pkg::CMD_BS_STEP: begin
          if (rent.pos <= hx) begin
            lo       <= mid;
            lo_owner <= rent.owner;
          end else begin
            hi <= mid;
          end
        end
        chrl_pkg::CMD_BS_DONE: owner_res <= lo_owner;
        chrl_pkg::CMD_FINISH: begin
          out_item.owner_node <= owner_res;
          if (op == chrl_pkg::OP_LOOKUP && count == CW'(0)) begin
            out_item.status <= chrl_pkg::ST_EMPTY;
          end else if (full_flag) begin
            out_item.status <= chrl_pkg::ST_FULL;
          end else begin
            out_item.status <= chrl_pkg::ST_OK;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/chrl_ctrl.sv]
// ----------------------------------------------------------------------------
// chrl_ctrl
// Sequencer for the four ring operations and the input/result handshakes.
// ----------------------------------------------------------------------------
module chrl_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  chrl_pkg::dp_status_t stat,
  output chrl_pkg::dp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_A_HSTART, S_A_HW, S_A_SRD, S_A_SCMP, S_A_INS,
    S_A_SHRD, S_A_SHWR, S_A_NEXT, S_R_RD, S_R_STEP, S_L_HW, S_L_LAST,
    S_L_CHK, S_L_BRD, S_L_BSTEP, S_FIN
  } state_t;

  state_t state, state_next;
  logic   slot_free;

  assign in_stall  = (state != S_IDLE);
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    cmd        = chrl_pkg::CMD_NONE;
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) begin
        cmd = chrl_pkg::CMD_LOAD; state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (stat.op)
          chrl_pkg::OP_CLEAR: begin
            cmd = chrl_pkg::CMD_CLEAR; state_next = S_FIN;
          end
          chrl_pkg::OP_ADD: state_next = S_A_HSTART;
          chrl_pkg::OP_REMOVE: begin
            cmd = chrl_pkg::CMD_RM_INIT; state_next = S_R_RD;
          end
          default: begin
            if (stat.count_zero) begin
              state_next = S_FIN;
            end else begin
              cmd = chrl_pkg::CMD_HKEY; state_next = S_L_HW;
            end
          end
        endcase
      end
      S_A_HSTART: begin
        cmd = chrl_pkg::CMD_HSEED; state_next = S_A_HW;
      end
      S_A_HW: if (stat.hash_done) begin
        cmd = chrl_pkg::CMD_SRCH_INIT; state_next = S_A_SRD;
      end
      S_A_SRD: begin
        if (stat.i_lt_count) begin
          cmd = chrl_pkg::CMD_SRCH_RD; state_next = S_A_SCMP;
        end else begin
          state_next = S_A_INS;
        end
      end
      S_A_SCMP: begin
        if (stat.pos_lt_h) begin
          cmd = chrl_pkg::CMD_SRCH_NEXT; state_next = S_A_SRD;
        end else if (stat.pos_eq_h) begin
          cmd = chrl_pkg::CMD_OVERWRITE; state_next = S_A_NEXT;
        end else begin
          state_next = S_A_INS;
        end
      end
      S_A_INS: begin
        if (stat.table_full) begin
          cmd = chrl_pkg::CMD_SET_FULL; state_next = S_A_NEXT;
        end else begin
          cmd = chrl_pkg::CMD_SHIFT_INIT; state_next = S_A_SHRD;
        end
      end
      S_A_SHRD: begin
        if (stat.k_gt_i) begin
          cmd = chrl_pkg::CMD_SHIFT_RD; state_next = S_A_SHWR;
        end else begin
          cmd = chrl_pkg::CMD_INSERT; state_next = S_A_NEXT;
        end
      end
      S_A_SHWR: begin
        cmd = chrl_pkg::CMD_SHIFT_WR; state_next = S_A_SHRD;
      end
      S_A_NEXT: begin
        if (stat.j_last) begin
          state_next = S_FIN;
        end else begin
          cmd = chrl_pkg::CMD_NEXT_POINT; state_next = S_A_HSTART;
        end
      end
      S_R_RD: begin
        if (stat.rd_lt_count) begin
          cmd = chrl_pkg::CMD_RM_RD; state_next = S_R_STEP;
        end else begin
          cmd = chrl_pkg::CMD_RM_DONE; state_next = S_FIN;
        end
      end
      S_R_STEP: begin
        cmd = chrl_pkg::CMD_RM_STEP; state_next = S_R_RD;
      end
      S_L_HW: if (stat.hash_done) begin
        cmd = chrl_pkg::CMD_LK_FIRST; state_next = S_L_LAST;
      end
      S_L_LAST: begin
        cmd = chrl_pkg::CMD_LK_LAST; state_next = S_L_CHK;
      end
      S_L_CHK: begin
        if (stat.outside) begin
          cmd = chrl_pkg::CMD_LK_WRAP; state_next = S_FIN;
        end else begin
          cmd = chrl_pkg::CMD_BS_INIT; state_next = S_L_BRD;
        end
      end
      S_L_BRD: begin
        if (stat.gap_gt1) begin
          cmd = chrl_pkg::CMD_BS_RD; state_next = S_L_BSTEP;
        end else begin
          cmd = chrl_pkg::CMD_BS_DONE; state_next = S_FIN;
        end
      end
      S_L_BSTEP: begin
        cmd = chrl_pkg::CMD_BS_STEP; state_next = S_L_BRD;
      end
      S_FIN: if (slot_free) begin
        cmd = chrl_pkg::CMD_FINISH; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FIN && slot_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/consistent_hash_ring_lookup_unit.sv]
// ----------------------------------------------------------------------------
// consistent_hash_ring_lookup_unit
// Sorted consistent-hashing ring with clear, add node, remove node and lookup.
// ----------------------------------------------------------------------------
// One item is worked on at a time and each gives one result item. For a
// lookup the triple hash runs on one shared 64x16 multiplier and the binary
// search makes one probe at a time on the table's single read port. Add
// hashes each of the node's points, scans the entries below the new position
// and shifts the entries above it. Remove makes one table read per entry.
// A finished result waits in an output register while the next item is taken.
module consistent_hash_ring_lookup_unit #(
  parameter int POINTS_PER_NODE = 16,
  parameter int RING_DEPTH      = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  chrl_pkg::in_t  in_item,
  output logic           out_valid,
  input  logic           out_stall,
  output chrl_pkg::out_t out_item
);

  chrl_pkg::dp_cmd_t    cmd;
  chrl_pkg::dp_status_t stat;

  chrl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  chrl_datapath #(
    .POINTS_PER_NODE (POINTS_PER_NODE),
    .RING_DEPTH      (RING_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_item  (in_item),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

[rtl/chrl_checker.sv]
// ----------------------------------------------------------------------------
// chrl_checker
// Port-level checks of the ring lookup unit, bound to its top level.
// ----------------------------------------------------------------------------
`include "consistent_hash_ring_lookup_unit_macros.svh"

module chrl_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input chrl_pkg::in_t  in_item,
  input logic           out_valid,
  input logic           out_stall,
  input chrl_pkg::out_t out_item
);

  // A held result keeps its value until it is taken.
  `CHRL_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_item))

  // An accepted item keeps the input side busy while it is worked on.
  `CHRL_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)

  // No result appears right after reset.
  `CHRL_ASSERT_IMPLY(a_no_result_after_reset, clk, rst, $past(rst), !out_valid)

  // A lookup on an empty ring names no owner.
  `CHRL_ASSERT_IMPLY(a_empty_no_owner, clk, rst, out_valid && out_item.status == chrl_pkg::ST_EMPTY, out_item.owner_node == 16'd0)

endmodule

bind consistent_hash_ring_lookup_unit chrl_checker u_chrl_checker (.*);

[tb/consistent_hash_ring_lookup_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// consistent_hash_ring_lookup_unit_tb
// Checks the ring lookup unit against a behavioral ring model: directed cases
// for the empty ring, extremes, a full table and node removal, then random
// mixes of clear, add, remove and lookup under several idling patterns.
// ----------------------------------------------------------------------------
module consistent_hash_ring_lookup_unit_tb;

  localparam int POINTS = 16;
  localparam int DEPTH = 256;
  localparam int WATCHDOG_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  chrl_pkg::in_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  chrl_pkg::out_t out_item;

  consistent_hash_ring_lookup_unit #(
    .POINTS_PER_NODE(POINTS),
    .RING_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item)
  );

  always #5 clk = ~clk;

  // Ring model state.
  logic [63:0] ring_pos[DEPTH];
  logic [15:0] ring_own[DEPTH];
  int point_total;

  chrl_pkg::out_t expected_results[$];
  int mismatches;
  int items_sent;
  int results_seen;
  int lookups_sent;
  int full_seen;
  int sender_idle_pct;
  int stall_pct;
  int idle_cycles;

  function automatic logic [63:0] mix_chunks(logic [63:0] x);
    logic [63:0] h;
    h = 64'd8;
    h = h * 64'd40343 + {48'd0, x[15:0]};
    h = h * 64'd40343 + {48'd0, x[31:16]};
    h = h * 64'd40343 + {48'd0, x[47:32]};
    h = h * 64'd40343 + {48'd0, x[63:48]};
    h = h * 64'd40343;
    return h;
  endfunction

  function automatic logic [63:0] triple_hash(logic [63:0] x);
    return mix_chunks(mix_chunks(mix_chunks(x)));
  endfunction

  // Returns 1 when the point is dropped because the table is full.
  function automatic bit insert_position(logic [63:0] pos, logic [15:0] owner);
    int i;
    i = 0;
    while (i < point_total && ring_pos[i] < pos) i++;
    if (i < point_total && ring_pos[i] == pos) begin
      ring_own[i] = owner;
      return 1'b0;
    end
    if (point_total >= DEPTH) return 1'b1;
    for (int k = point_total; k > i; k--) begin
      ring_pos[k] = ring_pos[k-1];
      ring_own[k] = ring_own[k-1];
    end
    ring_pos[i] = pos;
    ring_own[i] = owner;
    point_total++;
    return 1'b0;
  endfunction

  function automatic logic [15:0] owner_of_hash(logic [63:0] h);
    int last;
    int lo;
    int hi;
    int mid;
    last = point_total - 1;
    if (h < ring_pos[0] || h >= ring_pos[last]) return ring_own[last];
    lo = 0;
    hi = last;
    while (hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      if (ring_pos[mid] <= h) lo = mid;
      else hi = mid;
    end
    return ring_own[lo];
  endfunction

  function automatic chrl_pkg::out_t ring_update(chrl_pkg::in_t item);
    chrl_pkg::out_t r;
    bit dropped;
    int wr;
    r = '0;
    r.status = chrl_pkg::ST_OK;
    case (item.opcode)
      chrl_pkg::OP_CLEAR: begin
        point_total = 0;
      end
      chrl_pkg::OP_ADD: begin
        dropped = 1'b0;
        for (int j = 0; j < POINTS; j++) begin
          if (insert_position(triple_hash({48'd0, item.node_id} * POINTS + j),
                              item.node_id))
            dropped = 1'b1;
        end
        if (dropped) r.status = chrl_pkg::ST_FULL;
      end
      chrl_pkg::OP_REMOVE: begin
        wr = 0;
        for (int rd = 0; rd < point_total; rd++) begin
          if (ring_own[rd] != item.node_id) begin
            ring_pos[wr] = ring_pos[rd];
            ring_own[wr] = ring_own[rd];
            wr++;
          end
        end
        point_total = wr;
      end
      default: begin
        if (point_total == 0) r.status = chrl_pkg::ST_EMPTY;
        else r.owner_node = owner_of_hash(triple_hash(item.key));
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch on result %0d: %s got %0h expected %0h",
             results_seen, what, got, want);
    mismatches++;
  endtask

  // Drives one item, holding it until accepted, and records its expected result.
  task automatic send_item(logic [1:0] op, logic [15:0] node, logic [63:0] key);
    chrl_pkg::in_t item;
    chrl_pkg::out_t want;
    item.opcode = op;
    item.node_id = node;
    item.key = key;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (!(in_valid && !in_stall));
    want = ring_update(item);
    expected_results.insert(expected_results.size(), want);
    items_sent++;
    if (op == chrl_pkg::OP_LOOKUP) lookups_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Result checker and receiver stall.
  always @(posedge clk) begin
    chrl_pkg::out_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected item, owner_node", out_item.owner_node, 16'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_item.owner_node !== want.owner_node)
            report_mismatch("owner_node", out_item.owner_node, want.owner_node);
          if (out_item.status !== want.status)
            report_mismatch("status", {14'd0, out_item.status}, {14'd0, want.status});
          if (out_item.status == chrl_pkg::ST_FULL) full_seen++;
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: cycles with no handshake on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results pending", expected_results.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic test_empty_and_extremes();
    send_item(chrl_pkg::OP_LOOKUP, 16'h0000, 64'd0);
    send_item(chrl_pkg::OP_REMOVE, 16'hFFFF, 64'd0);
    send_item(chrl_pkg::OP_ADD, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(chrl_pkg::OP_LOOKUP, 16'hFFFF, 64'd0);
    send_item(chrl_pkg::OP_LOOKUP, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(chrl_pkg::OP_ADD, 16'hFFFF, 64'd0);
    // Adding a node again overwrites positions that are already present.
    send_item(chrl_pkg::OP_ADD, 16'hFFFF, 64'd0);
    send_item(chrl_pkg::OP_LOOKUP, 16'h0000, 64'hAAAA_5555_AAAA_5555);
    send_item(chrl_pkg::OP_LOOKUP, 16'h0000, 64'h5555_AAAA_5555_AAAA);
    send_item(chrl_pkg::OP_REMOVE, 16'h1234, 64'd0);
    send_item(chrl_pkg::OP_REMOVE, 16'h0000, 64'd0);
    send_item(chrl_pkg::OP_LOOKUP, 16'h0000, 64'h0123_4567_89AB_CDEF);
    send_item(chrl_pkg::OP_CLEAR, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(chrl_pkg::OP_LOOKUP, 16'h0000, 64'h1);
  endtask

  // Seventeen nodes overflow a table that holds sixteen nodes' points.
  task automatic test_full_table();
    for (int n = 1; n <= 17; n++) send_item(chrl_pkg::OP_ADD, 16'(n * 3855), 64'd0);
    send_item(chrl_pkg::OP_ADD, 16'd3855, 64'd0);
    send_item(chrl_pkg::OP_LOOKUP, 16'd0, 64'hFFFF_FFFF_0000_0000);
    send_item(chrl_pkg::OP_REMOVE, 16'd7710, 64'd0);
    send_item(chrl_pkg::OP_ADD, 16'd77, 64'd0);
    drain_results();
    send_item(chrl_pkg::OP_CLEAR, 16'd0, 64'd0);
  endtask

  task automatic test_random_mix(int count, int idle_pct, int stall_p);
    int pick;
    logic [15:0] node;
    sender_idle_pct = idle_pct;
    stall_pct = stall_p;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      node = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(23));
      if (pick < 3) send_item(chrl_pkg::OP_CLEAR, 16'($urandom), {$urandom, $urandom});
      else if (pick < 12) send_item(chrl_pkg::OP_ADD, node, {$urandom, $urandom});
      else if (pick < 21) send_item(chrl_pkg::OP_REMOVE, node, {$urandom, $urandom});
      else send_item(chrl_pkg::OP_LOOKUP, 16'($urandom), {$urandom, $urandom});
    end
  endtask

  initial begin
    mismatches = 0;
    items_sent = 0;
    results_seen = 0;
    lookups_sent = 0;
    full_seen = 0;
    sender_idle_pct = 0;
    stall_pct = 0;
    point_total = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_and_extremes();
    test_full_table();
    test_random_mix(400, 0, 0);
    drain_results();
    test_random_mix(400, 80, 0);
    test_random_mix(400, 0, 80);
    test_random_mix(400, 27, 27);

    drain_results();
    repeat (100) @(posedge clk);
    $display("ran %0d items (%0d lookups), %0d results checked, %0d full-table adds",
             items_sent, lookups_sent, results_seen, full_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches,
               expected_results.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
